>>> hdl/csvfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared constants, widths and types of the CSV record and field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  localparam int MAX_RECORD_BYTES   = 8192;
  localparam int MAX_FIELD_BYTES    = 1024;
  localparam int MAX_PENDING_BLANKS = 32;
  localparam int MAX_FIELDS         = 64;

  localparam int FIELD_CAP = ((MAX_FIELDS - 1) > 63) ? 63 : (MAX_FIELDS - 1);

  localparam int RL_W = $clog2(MAX_RECORD_BYTES);
  localparam int FL_W = $clog2(MAX_FIELD_BYTES);
  localparam int PC_W = $clog2(MAX_PENDING_BLANKS + 1);
  localparam int PI_W = (MAX_PENDING_BLANKS > 1) ? $clog2(MAX_PENDING_BLANKS) : 1;
  localparam int FN_W = 6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One unit of work for the emitter: optional pending blanks plus a data
  // byte, then up to two field-end marks.
  typedef struct packed {
    logic                          emit_data;
    logic [PC_W-1:0]               blank_count;
    logic [MAX_PENDING_BLANKS-1:0] blank_mask;   // 1 = tab, 0 = space
    logic [7:0]                    data;
    logic                          end_a;
    logic                          re_a;
    logic                          end_b;        // always a record end
    logic [FN_W-1:0]               fn_a;
    logic                          ov_a;
    logic [FN_W-1:0]               fn_b;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_BLANK = 4'b0001,
    ST_DATA  = 4'b0010,
    ST_END_A = 4'b0100,
    ST_END_B = 4'b1000
  } stage_t;

endpackage

>>> hdl/csvfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_front
// Parses one byte per accepted item, tracks quote, record and field state,
// holds pending blanks, and issues emit commands.
// ----------------------------------------------------------------------------
module csvfs_front
  import csvfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic                          quoted, quoted_next;
  logic [RL_W-1:0]               record_length, record_length_next;
  logic [FL_W-1:0]               field_length, field_length_next;
  logic                          seen_nonblank, seen_nonblank_next;
  logic [PC_W-1:0]               pending_count, pending_count_next;
  logic [FN_W-1:0]               field_counter, field_counter_next;
  logic                          overflow_seen, overflow_seen_next;
  logic [MAX_PENDING_BLANKS-1:0] pending_blanks;

  logic                          blank_write;
  logic                          is_blank;
  logic [RL_W:0]                 rl_inc;
  logic [FN_W-1:0]               fc_inc;
  logic                          close_rec;
  logic                          comma_close;

  assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
  assign rl_inc   = {1'b0, record_length} + (RL_W + 1)'(1);
  assign fc_inc   = (field_counter < FN_W'(FIELD_CAP)) ? field_counter + FN_W'(1)
                                                       : field_counter;

  always_comb begin
    quoted_next        = quoted;
    record_length_next = record_length;
    field_length_next  = field_length;
    seen_nonblank_next = seen_nonblank;
    pending_count_next = pending_count;
    field_counter_next = field_counter;
    overflow_seen_next = overflow_seen;
    blank_write        = 1'b0;
    close_rec          = 1'b0;
    comma_close        = 1'b0;

    cmd             = '0;
    cmd.blank_count = pending_count;
    cmd.blank_mask  = pending_blanks;
    cmd.data        = in_byte;
    cmd.fn_a        = field_counter;
    cmd.fn_b        = fc_inc;

    if (end_of_input) begin
      close_rec = (record_length != '0);
    end else if ((in_byte == CH_LF) && !quoted) begin
      close_rec = 1'b1;
    end else begin
      if (in_byte == CH_QUOTE) begin
        quoted_next = !quoted;
      end else if ((in_byte == CH_COMMA) && !quoted) begin
        comma_close        = 1'b1;
        cmd.end_a          = 1'b1;
        field_length_next  = '0;
        seen_nonblank_next = 1'b0;
        pending_count_next = '0;
        overflow_seen_next = 1'b0;
        field_counter_next = fc_inc;
      end else if (field_length < FL_W'(MAX_FIELD_BYTES - 1)) begin
        field_length_next = field_length + FL_W'(1);
        if (in_byte == CH_CR) begin
          // drop
        end else if (is_blank) begin
          if (seen_nonblank) begin
            if (pending_count < PC_W'(MAX_PENDING_BLANKS)) begin
              blank_write        = 1'b1;
              pending_count_next = pending_count + PC_W'(1);
            end else begin
              overflow_seen_next = 1'b1;
            end
          end
        end else begin
          cmd.emit_data      = 1'b1;
          pending_count_next = '0;
          seen_nonblank_next = 1'b1;
        end
      end
      record_length_next = rl_inc[RL_W-1:0];
      if (rl_inc >= (RL_W + 1)'(MAX_RECORD_BYTES - 1)) begin
        close_rec = 1'b1;
      end
    end

    // A comma end mark reports the flag of the field it closes.
    cmd.ov_a = comma_close ? overflow_seen : overflow_seen_next;
    if (close_rec) begin
      if (comma_close) begin
        cmd.end_b = 1'b1;
      end else begin
        cmd.end_a = 1'b1;
        cmd.re_a  = 1'b1;
      end
      quoted_next        = 1'b0;
      record_length_next = '0;
      field_length_next  = '0;
      seen_nonblank_next = 1'b0;
      pending_count_next = '0;
      field_counter_next = '0;
      overflow_seen_next = 1'b0;
    end
  end

  assign cmd_push = accept && (cmd.emit_data || cmd.end_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      quoted        <= 1'b0;
      record_length <= '0;
      field_length  <= '0;
      seen_nonblank <= 1'b0;
      pending_count <= '0;
      field_counter <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      quoted        <= quoted_next;
      record_length <= record_length_next;
      field_length  <= field_length_next;
      seen_nonblank <= seen_nonblank_next;
      pending_count <= pending_count_next;
      field_counter <= field_counter_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Pending blank store: only entries written in the current field are read.
  always_ff @(posedge clk) begin
    if (accept && blank_write) begin
      pending_blanks[pending_count[PI_W-1:0]] <= (in_byte == CH_TAB);
    end
  end

endmodule

>>> hdl/csvfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_queue
// Short command queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module csvfs_queue
  import csvfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t          entries [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QP_W:0]   count;

  assign full       = (count == (QP_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QP_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QP_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QP_W + 1)'(1);
        2'b01:   count <= count - (QP_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/csvfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvfs_back
// Walks the command at the queue head into the output register, one result a
// cycle unless out_stall holds a valid output.
// ----------------------------------------------------------------------------
module csvfs_back
  import csvfs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  cmd_t            head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            field_end,
  output logic            record_end,
  output logic [FN_W-1:0] field_number,
  output logic            blank_overflow,
  output logic            last
);

  logic            busy;
  stage_t          stage;
  logic [PI_W-1:0] blank_idx;

  stage_t          cur_stage;
  stage_t          stage_next;
  logic [PI_W-1:0] cur_idx;
  logic [PC_W-1:0] idx_inc;
  logic            load;

  logic [7:0]      r_byte;
  logic            r_valid;
  logic            r_fe;
  logic            r_re;
  logic [FN_W-1:0] r_fn;
  logic            r_ov;
  logic            r_last;

  always_comb begin
    if (busy) begin
      cur_stage = stage;
    end else if (head.emit_data && (head.blank_count != '0)) begin
      cur_stage = ST_BLANK;
    end else if (head.emit_data) begin
      cur_stage = ST_DATA;
    end else begin
      cur_stage = ST_END_A;
    end
  end

  assign cur_idx = busy ? blank_idx : '0;
  assign idx_inc = PC_W'(cur_idx) + PC_W'(1);

  always_comb begin
    r_byte     = 8'h00;
    r_valid    = 1'b0;
    r_fe       = 1'b0;
    r_re       = 1'b0;
    r_fn       = head.fn_a;
    r_ov       = head.ov_a;
    r_last     = 1'b0;
    stage_next = cur_stage;
    case (cur_stage)
      ST_BLANK: begin
        r_byte  = head.blank_mask[cur_idx] ? CH_TAB : CH_SPACE;
        r_valid = 1'b1;
        if (idx_inc == head.blank_count) begin
          stage_next = ST_DATA;
        end
      end
      ST_DATA: begin
        r_byte     = head.data;
        r_valid    = 1'b1;
        r_last     = !head.end_a;
        stage_next = ST_END_A;
      end
      ST_END_A: begin
        r_fe       = 1'b1;
        r_re       = head.re_a;
        r_last     = !head.end_b;
        stage_next = ST_END_B;
      end
      ST_END_B: begin
        r_fe   = 1'b1;
        r_re   = 1'b1;
        r_fn   = head.fn_b;
        r_ov   = 1'b0;
        r_last = 1'b1;
      end
      default: begin
        r_last = 1'b1;
      end
    endcase
  end

  assign load = head_valid && (!out_valid || !out_stall);
  assign pop  = load && r_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      stage     <= ST_BLANK;
      blank_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        busy      <= !r_last;
        stage     <= stage_next;
        blank_idx <= idx_inc[PI_W-1:0];
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= r_byte;
      byte_valid     <= r_valid;
      field_end      <= r_fe;
      record_end     <= r_re;
      field_number   <= r_fn;
      blank_overflow <= r_ov;
      last           <= r_last;
    end
  end

endmodule

>>> hdl/csv_record_field_splitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_record_field_splitter_top
// With an empty command queue, the first result of an item is registered in
// the command queue and then in the output register; later results follow one
// a cycle while out_stall allows. Throughput: one input item a cycle while the
// 4-entry command queue has room; the emitter gives one result a cycle unless
// out_stall holds it (a non-blank byte releases up to 32 pending blanks).
// Reset: synchronous, clears parser state, queue pointers and output valid.
// ----------------------------------------------------------------------------
module csv_record_field_splitter_top
  import csvfs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            end_of_input,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            field_end,
  output logic            record_end,
  output logic [FN_W-1:0] field_number,
  output logic            blank_overflow,
  output logic            last
);

  // Front to queue: an item is taken only when the queue can take its
  // command, even if it turns out to produce none.
  logic accept;
  logic cmd_push;
  cmd_t cmd;
  logic q_full;

  // Queue to back.
  logic head_valid;
  cmd_t head;
  logic pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Parse the byte, update record and field state, queue any output work.
  csvfs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .cmd_push     (cmd_push),
    .cmd          (cmd)
  );

  // Decouple parsing from emission so blank bursts do not stall input at once.
  csvfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Emit blanks, data byte and end marks in order; drop the command when done.
  csvfs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .field_end      (field_end),
    .record_end     (record_end),
    .field_number   (field_number),
    .blank_overflow (blank_overflow),
    .last           (last)
  );

endmodule
